FILE: sv/psjb_pkg.sv
// Shared constants and types for the packet sample jitter buffer.
`default_nettype none

package psjb_pkg;

    // Ring geometry and packet framing.
    localparam int RING_DEPTH     = 16384;
    localparam int PTR_W          = $clog2(RING_DEPTH);
    localparam int PACKET_SAMPLES = 255;
    localparam int SMP_W          = 8;
    localparam int STATUS_EVERY   = 7;
    localparam int STAT_W         = $clog2(STATUS_EVERY + 1);

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 16;
    localparam int REQ_W    = 3;
    localparam int DROP_W   = 2;
    localparam int FLAG_W   = 2;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 16;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 72;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_HEADER = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PULL   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ARM    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SRST   = 3'd5;

    // Drop reasons.
    localparam logic [DROP_W-1:0] DROP_NONE  = 2'd0;
    localparam logic [DROP_W-1:0] DROP_INDEX = 2'd1;
    localparam logic [DROP_W-1:0] DROP_FULL  = 2'd2;

    // Sticky flag bits.
    localparam logic [FLAG_W-1:0] FLAG_UNDERRUN = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_OVERRUN  = 2'b10;

    // Configuration register indexes.
    localparam logic [CFG_A_W-1:0] CFG_RX_ENABLE  = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_IDLE_LEVEL = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_PREFILL    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [SAMPLE_W-1:0] IDLE_LEVEL_RST = 16'd2048;
    localparam logic [PTR_W-1:0]    PREFILL_RST    = PTR_W'(RING_DEPTH / 2);

    // Derived ring constants.
    localparam logic [PTR_W-1:0] RING_MAX    = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W-1:0] PKT_LEN_PTR = PTR_W'(PACKET_SAMPLES);
    localparam logic [SMP_W-1:0] PKT_LEN_SMP = SMP_W'(PACKET_SAMPLES);
    localparam logic [STAT_W-1:0] STAT_LAST  = STAT_W'(STATUS_EVERY - 1);

    // Controller states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WAIT = 1'b1;

    // One result item.
    typedef struct packed {
        logic [INDEX_W-1:0]  expected_index;
        logic [FLAG_W-1:0]   error_flags;
        logic [INDEX_W-1:0]  status_index;
        logic [PTR_W-1:0]    status_fill;
        logic                status_due;
        logic                start_dac;
        logic [DROP_W-1:0]   drop_reason;
        logic                accepted;
        logic [SAMPLE_W-1:0] sample_out;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/psjb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module psjb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/packet_sample_jitter_buffer.sv
// Top level of the packet sample jitter buffer: request decoder, ring control and result register.
`default_nettype none

// The block keeps a ring of 16384 16-bit samples in one RAM, of which 16383 are usable.
// Each input item carries a request kind in tuser and yields exactly one result item.
// Headers, samples, flag clears, arm and soft reset load the result register directly.
// A DAC pull from a non-empty ring adds a wait state, since RAM read data is registered.
// A full result register stalls the input until the result item is taken. With an
// empty ring, a pull returns idle_level and sets the underrun flag. Samples of an open
// packet are written to the ring as they arrive but stay hidden until the last one.
// The ring needs no clearing pass after reset, and only committed entries are read.
module packet_sample_jitter_buffer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port.
    input  wire logic                          i_cfg_we,
    input  wire logic [psjb_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  wire logic [psjb_pkg::CFG_D_W-1:0]  i_cfg_wdata,
    // Input stream.
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: header_index [15:0], sample_value [31:16].
    input  wire logic [psjb_pkg::IN_W-1:0]     i_s_tdata,
    // tuser: req_type [2:0].
    input  wire logic [psjb_pkg::REQ_W-1:0]    i_s_tuser,
    // Result stream.
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // tdata: sample_out [15:0], accepted [16], drop_reason [18:17], start_dac [19],
    // status_due [20], status_fill [34:21], status_index [50:35], error_flags [52:51],
    // expected_index [68:53], zero [71:69].
    output logic      [psjb_pkg::OUT_W-1:0]    o_m_tdata
);

    // Configuration registers.
    logic                          r_rx_enable;
    logic [psjb_pkg::SAMPLE_W-1:0] r_idle_level;
    logic [psjb_pkg::PTR_W-1:0]    r_prefill;

    // Control state.
    logic                          r_state;
    logic                          r_out_valid;
    logic [psjb_pkg::PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [psjb_pkg::PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [psjb_pkg::INDEX_W-1:0]  r_next_idx, n_next_idx;
    logic [psjb_pkg::FLAG_W-1:0]   r_flags, n_flags;
    logic                          r_start_pend, n_start_pend;
    logic                          r_pkt_open, n_pkt_open;
    logic [psjb_pkg::SMP_W-1:0]    r_smp_cnt, n_smp_cnt;
    logic [psjb_pkg::STAT_W-1:0]   r_stat_cnt, n_stat_cnt;

    // Result register.
    psjb_pkg::t_result             r_result, n_result;

    // Ring access.
    logic                          w_ram_we;
    logic [psjb_pkg::PTR_W-1:0]    w_ram_waddr;
    logic                          w_ram_re;
    logic [psjb_pkg::SAMPLE_W-1:0] w_ram_rdata;

    // Decoded input item.
    logic                          w_accept;
    logic [psjb_pkg::REQ_W-1:0]    w_req;
    logic [psjb_pkg::INDEX_W-1:0]  w_pidx;
    logic [psjb_pkg::SAMPLE_W-1:0] w_sval;
    logic [psjb_pkg::PTR_W-1:0]    w_fill;
    logic [psjb_pkg::PTR_W-1:0]    w_room;
    logic [psjb_pkg::PTR_W-1:0]    w_fill_new;
    logic [psjb_pkg::SMP_W-1:0]    w_cnt_inc;
    logic                          w_pull_read;

    assign w_req  = i_s_tuser;
    assign w_pidx = i_s_tdata[15:0];
    assign w_sval = i_s_tdata[31:16];

    // Input is taken only in the idle state and when the result register can be loaded.
    assign o_s_tready = (r_state == psjb_pkg::ST_IDLE) && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Ring occupancy; the depth is a power of two, so the pointers wrap naturally.
    assign w_fill     = r_wr_ptr - r_rd_ptr;
    assign w_room     = psjb_pkg::RING_MAX - w_fill;
    assign w_fill_new = r_wr_ptr + psjb_pkg::PKT_LEN_PTR - r_rd_ptr;
    assign w_cnt_inc  = r_smp_cnt + psjb_pkg::SMP_W'(1);

    // Staged sample write past the write pointer, offset by the staged sample count.
    assign w_ram_we    = w_accept && (w_req == psjb_pkg::REQ_SAMPLE) && r_rx_enable
                         && r_pkt_open;
    assign w_ram_waddr = r_wr_ptr + psjb_pkg::PTR_W'(r_smp_cnt);

    // A pull from a non-empty ring reads at the read pointer.
    assign w_pull_read = w_accept && (w_req == psjb_pkg::REQ_PULL)
                         && (w_fill != '0);
    assign w_ram_re    = w_pull_read;

    psjb_ram #(
        .WIDTH (psjb_pkg::SAMPLE_W),
        .DEPTH (psjb_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_sval),
        .i_re    (w_ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_ram_rdata)
    );

    // Next state and result for the item at the input.
    always_comb begin
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_next_idx   = r_next_idx;
        n_flags      = r_flags;
        n_start_pend = r_start_pend;
        n_pkt_open   = r_pkt_open;
        n_smp_cnt    = r_smp_cnt;
        n_stat_cnt   = r_stat_cnt;
        n_result     = '0;

        case (w_req)
            psjb_pkg::REQ_HEADER: begin
                if (r_rx_enable) begin
                    n_pkt_open = 1'b0;
                    n_smp_cnt  = '0;
                    if (w_pidx != r_next_idx) begin
                        n_result.drop_reason = psjb_pkg::DROP_INDEX;
                    end else if (psjb_pkg::PKT_LEN_PTR > w_room) begin
                        n_result.drop_reason = psjb_pkg::DROP_FULL;
                        n_flags = r_flags | psjb_pkg::FLAG_OVERRUN;
                    end else begin
                        n_result.accepted = 1'b1;
                        n_pkt_open = 1'b1;
                    end
                end
            end
            psjb_pkg::REQ_SAMPLE: begin
                if (r_rx_enable && r_pkt_open) begin
                    n_smp_cnt = w_cnt_inc;
                    // Last sample commits the whole packet.
                    if (w_cnt_inc >= psjb_pkg::PKT_LEN_SMP) begin
                        n_wr_ptr   = r_wr_ptr + psjb_pkg::PKT_LEN_PTR;
                        n_pkt_open = 1'b0;
                        n_smp_cnt  = '0;
                        n_next_idx = r_next_idx + psjb_pkg::INDEX_W'(1);
                        // The counter follows the next index modulo STATUS_EVERY and
                        // restarts together with the index when the index wraps.
                        n_stat_cnt = ((r_stat_cnt == psjb_pkg::STAT_LAST) || (&r_next_idx))
                                     ? '0 : r_stat_cnt + psjb_pkg::STAT_W'(1);
                        if (r_start_pend && (w_fill_new >= r_prefill)) begin
                            n_result.start_dac = 1'b1;
                            n_start_pend = 1'b0;
                        end
                        if (n_stat_cnt == '0) begin
                            n_result.status_due   = 1'b1;
                            n_result.status_fill  = w_fill_new;
                            n_result.status_index = r_next_idx;
                        end
                    end
                end
            end
            psjb_pkg::REQ_PULL: begin
                if (w_fill == '0) begin
                    n_result.sample_out = r_idle_level;
                    n_flags = r_flags | psjb_pkg::FLAG_UNDERRUN;
                end else begin
                    n_rd_ptr = r_rd_ptr + psjb_pkg::PTR_W'(1);
                end
            end
            psjb_pkg::REQ_ARM: begin
                n_start_pend = 1'b1;
            end
            psjb_pkg::REQ_SRST: begin
                n_wr_ptr     = '0;
                n_rd_ptr     = '0;
                n_next_idx   = '0;
                n_flags      = '0;
                n_start_pend = 1'b0;
                n_pkt_open   = 1'b0;
                n_smp_cnt    = '0;
                n_stat_cnt   = '0;
            end
            default: begin
            end
        endcase

        n_result.error_flags    = n_flags;
        n_result.expected_index = n_next_idx;
        // Read-clear reports the flags as they were before clearing.
        if (w_req == psjb_pkg::REQ_CLEAR) begin
            n_flags = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_enable  <= 1'b1;
            r_idle_level <= psjb_pkg::IDLE_LEVEL_RST;
            r_prefill    <= psjb_pkg::PREFILL_RST;
            r_state      <= psjb_pkg::ST_IDLE;
            r_out_valid  <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_next_idx   <= '0;
            r_flags      <= '0;
            r_start_pend <= 1'b0;
            r_pkt_open   <= 1'b0;
            r_smp_cnt    <= '0;
            r_stat_cnt   <= '0;
        end else begin
            // Configuration writes; unknown indexes are ignored.
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    psjb_pkg::CFG_RX_ENABLE:  r_rx_enable  <= i_cfg_wdata[0];
                    psjb_pkg::CFG_IDLE_LEVEL: r_idle_level <= i_cfg_wdata;
                    psjb_pkg::CFG_PREFILL:    r_prefill    <= i_cfg_wdata[psjb_pkg::PTR_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_accept) begin
                r_wr_ptr     <= n_wr_ptr;
                r_rd_ptr     <= n_rd_ptr;
                r_next_idx   <= n_next_idx;
                r_flags      <= n_flags;
                r_start_pend <= n_start_pend;
                r_pkt_open   <= n_pkt_open;
                r_smp_cnt    <= n_smp_cnt;
                r_stat_cnt   <= n_stat_cnt;
                if (w_pull_read) begin
                    r_state     <= psjb_pkg::ST_WAIT;
                    r_out_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (r_state == psjb_pkg::ST_WAIT) begin
                r_state     <= psjb_pkg::ST_IDLE;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; the pulled sample is taken from the RAM read data in the wait state.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end else if (r_state == psjb_pkg::ST_WAIT) begin
            r_result.sample_out <= w_ram_rdata;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_result};

    // A result is never shown while its ring read is still in flight.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psjb_pkg::ST_WAIT) |-> !r_out_valid)
        else $error("result valid during ring read");

    // A pull from a non-empty ring always goes through the read wait state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pull_read |=> (r_state == psjb_pkg::ST_WAIT))
        else $error("ring read without wait state");

    // An open packet never holds a full packet of staged samples.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pkt_open |-> (r_smp_cnt < psjb_pkg::PKT_LEN_SMP))
        else $error("open packet overfilled");

    // A header is never both accepted and dropped.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.accepted && (r_result.drop_reason != psjb_pkg::DROP_NONE)))
        else $error("header accepted and dropped");

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the packet sample jitter buffer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RES_W          = $bits(psjb_pkg::t_result);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTS     = 50;

    // Request codes the block treats as no-ops.
    localparam logic [psjb_pkg::REQ_W-1:0] REQ_UNUSED6 = 3'd6;
    localparam logic [psjb_pkg::REQ_W-1:0] REQ_UNUSED7 = 3'd7;

    // One row of the directed stimulus table.
    typedef struct packed {
        logic [psjb_pkg::REQ_W-1:0]    req;
        logic [psjb_pkg::INDEX_W-1:0]  pidx;
        logic [psjb_pkg::SAMPLE_W-1:0] sval;
        logic                          fixed;
        psjb_pkg::t_result             want;
    } t_stim_row;

    // Block ports.
    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [psjb_pkg::CFG_A_W-1:0]  i_cfg_addr  = '0;
    logic [psjb_pkg::CFG_D_W-1:0]  i_cfg_wdata = '0;
    logic                          i_s_tvalid  = 1'b0;
    logic                          o_s_tready;
    logic [psjb_pkg::IN_W-1:0]     i_s_tdata   = '0;
    logic [psjb_pkg::REQ_W-1:0]    i_s_tuser   = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready  = 1'b0;
    logic [psjb_pkg::OUT_W-1:0]    o_m_tdata;

    // Predictor state and its copy of the registers.
    logic [psjb_pkg::SAMPLE_W-1:0] ring_mem [psjb_pkg::RING_DEPTH];
    logic [psjb_pkg::PTR_W-1:0]    wr_ptr;
    logic [psjb_pkg::PTR_W-1:0]    rd_ptr;
    logic [psjb_pkg::INDEX_W-1:0]  exp_index;
    logic [psjb_pkg::FLAG_W-1:0]   flags_now;
    bit                            start_armed;
    bit                            pkt_open;
    int unsigned                   pkt_count;
    bit                            rx_on;
    logic [psjb_pkg::SAMPLE_W-1:0] idle_val;
    logic [psjb_pkg::PTR_W-1:0]    prefill_val;

    // Results still owed by the block, oldest first.
    psjb_pkg::t_result expected_results [$];
    t_stim_row dir_tab [$];

    // Run bookkeeping.
    bit no_idle = 1'b0;
    int n_items, n_results, n_errors, stall_cycles;
    int n_accepted, n_drops, n_starts, n_status;

    packet_sample_jitter_buffer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Number of committed samples currently held in the ring.
    function automatic logic [psjb_pkg::PTR_W-1:0] held_count();
        return wr_ptr - rd_ptr;
    endfunction

    // Clears everything a soft reset clears; the registers are kept.
    task automatic clear_buffer_state();
        wr_ptr      = '0;
        rd_ptr      = '0;
        exp_index   = '0;
        flags_now   = '0;
        start_armed = 1'b0;
        pkt_open    = 1'b0;
        pkt_count   = 0;
    endtask

    // Advances the predicted buffer by one input item and returns its result.
    task automatic jitter_buffer_step(input logic [psjb_pkg::REQ_W-1:0] req,
                                      input logic [psjb_pkg::INDEX_W-1:0] pidx,
                                      input logic [psjb_pkg::SAMPLE_W-1:0] sval,
                                      output psjb_pkg::t_result r);
        logic [psjb_pkg::PTR_W-1:0]   fill;
        logic [psjb_pkg::PTR_W-1:0]   slot;
        logic [psjb_pkg::INDEX_W-1:0] done;
        r = '0;
        case (req)
            psjb_pkg::REQ_HEADER: begin
                if (rx_on) begin
                    // A new header always abandons any staged samples.
                    pkt_open  = 1'b0;
                    pkt_count = 0;
                    if (pidx != exp_index) begin
                        r.drop_reason = psjb_pkg::DROP_INDEX;
                    end else if (psjb_pkg::PACKET_SAMPLES >
                                 psjb_pkg::RING_DEPTH - 1 - int'(held_count())) begin
                        r.drop_reason = psjb_pkg::DROP_FULL;
                        flags_now |= psjb_pkg::FLAG_OVERRUN;
                    end else begin
                        r.accepted = 1'b1;
                        pkt_open   = 1'b1;
                    end
                end
            end
            psjb_pkg::REQ_SAMPLE: begin
                if (rx_on && pkt_open) begin
                    slot = wr_ptr + psjb_pkg::PTR_W'(pkt_count);
                    ring_mem[slot] = sval;
                    pkt_count++;
                    // The last sample commits the whole packet.
                    if (pkt_count >= psjb_pkg::PACKET_SAMPLES) begin
                        done      = exp_index;
                        wr_ptr    = wr_ptr + psjb_pkg::PKT_LEN_PTR;
                        pkt_open  = 1'b0;
                        pkt_count = 0;
                        exp_index = exp_index + 1'b1;
                        fill      = held_count();
                        if (start_armed && fill >= prefill_val) begin
                            r.start_dac = 1'b1;
                            start_armed = 1'b0;
                        end
                        if (exp_index % psjb_pkg::STATUS_EVERY == 0) begin
                            r.status_due   = 1'b1;
                            r.status_fill  = fill;
                            r.status_index = done;
                        end
                    end
                end
            end
            psjb_pkg::REQ_PULL: begin
                if (held_count() == 0) begin
                    r.sample_out = idle_val;
                    flags_now |= psjb_pkg::FLAG_UNDERRUN;
                end else begin
                    r.sample_out = ring_mem[rd_ptr];
                    rd_ptr = rd_ptr + 1'b1;
                end
            end
            psjb_pkg::REQ_ARM:  start_armed = 1'b1;
            psjb_pkg::REQ_SRST: clear_buffer_state();
            default: ;
        endcase
        r.error_flags = flags_now;
        if (req == psjb_pkg::REQ_CLEAR) flags_now = '0;
        r.expected_index = exp_index;
    endtask

    // Builds a result that is easy to read off by hand; status fields stay zero.
    function automatic psjb_pkg::t_result directed_result(
            input logic [psjb_pkg::SAMPLE_W-1:0] smp,
            input logic acc,
            input logic [psjb_pkg::DROP_W-1:0] drop,
            input logic [psjb_pkg::FLAG_W-1:0] flg);
        psjb_pkg::t_result r;
        r             = '0;
        r.sample_out  = smp;
        r.accepted    = acc;
        r.drop_reason = drop;
        r.error_flags = flg;
        return r;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what,
                                   input logic [psjb_pkg::SAMPLE_W-1:0] got_v,
                                   input logic [psjb_pkg::SAMPLE_W-1:0] want_v);
        if (n_errors < MAX_PRINTS) begin
            $display("ERROR: result %0d, %s: got %0h, expected %0h",
                     n_results, what, got_v, want_v);
        end
        n_errors++;
    endtask

    // Offers one item, waits for it to be taken, then records its expected result.
    // A fixed result, where given, stands in for the predicted one.
    task automatic send_checked(input logic [psjb_pkg::REQ_W-1:0] req,
                                input logic [psjb_pkg::INDEX_W-1:0] pidx,
                                input logic [psjb_pkg::SAMPLE_W-1:0] sval,
                                input logic fixed,
                                input psjb_pkg::t_result want);
        psjb_pkg::t_result pred;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {sval, pidx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n_items++;
        jitter_buffer_step(req, pidx, sval, pred);
        n_accepted += pred.accepted;
        n_drops    += (pred.drop_reason != psjb_pkg::DROP_NONE);
        n_starts   += pred.start_dac;
        n_status   += pred.status_due;
        expected_results.push_back(fixed ? want : pred);
        // Occasional gap on the sending side.
        if (!no_idle && $urandom_range(0, 99) < 10) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send(input logic [psjb_pkg::REQ_W-1:0] req,
                        input logic [psjb_pkg::INDEX_W-1:0] pidx,
                        input logic [psjb_pkg::SAMPLE_W-1:0] sval);
        send_checked(req, pidx, sval, 1'b0, '0);
    endtask

    // Holds the input off until every owed result has come back.
    task automatic wait_results_done();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes one register; only called while the block is idle.
    task automatic cfg_write(input logic [psjb_pkg::CFG_A_W-1:0] addr,
                             input logic [psjb_pkg::CFG_D_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            psjb_pkg::CFG_RX_ENABLE:  rx_on = data[0];
            psjb_pkg::CFG_IDLE_LEVEL: idle_val = data;
            psjb_pkg::CFG_PREFILL:    prefill_val = data[psjb_pkg::PTR_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic pull_burst(input int count);
        repeat (count) send(psjb_pkg::REQ_PULL, 16'($urandom), 16'($urandom));
    endtask

    // A well-formed packet: correct header, then samples until it commits.
    // DAC pulls, and rarely a flag clear or an arm, are mixed into the payload.
    task automatic send_packet(input int pull_pct);
        int r;
        send(psjb_pkg::REQ_HEADER, exp_index, 16'($urandom));
        while (pkt_open && rx_on) begin
            r = $urandom_range(0, 99);
            if (r < pull_pct) send(psjb_pkg::REQ_PULL, 16'($urandom), 16'($urandom));
            else if (r == 99) send(($urandom_range(0, 1) != 0) ? psjb_pkg::REQ_CLEAR
                                                                : psjb_pkg::REQ_ARM,
                                   16'($urandom), 16'($urandom));
            else send(psjb_pkg::REQ_SAMPLE, 16'($urandom), 16'($urandom));
        end
    endtask

    // Random traffic: mostly whole packets and pull bursts, some broken packets and noise.
    task automatic random_mix(input int target, input int pull_pct);
        int stop;
        int sel;
        stop = n_items + target;
        while (n_items < stop) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                send_packet(pull_pct);
            end else if (sel < 72) begin
                pull_burst($urandom_range(1, 40));
            end else if (sel < 84) begin
                // Header, possibly with a wrong index, and a truncated payload.
                send(psjb_pkg::REQ_HEADER,
                     ($urandom_range(0, 3) == 0) ? 16'($urandom) : exp_index,
                     16'($urandom));
                repeat ($urandom_range(0, 60))
                    send(psjb_pkg::REQ_SAMPLE, 16'($urandom), 16'($urandom));
            end else if (sel < 88) begin
                send(psjb_pkg::REQ_ARM, 16'($urandom), 16'($urandom));
            end else begin
                send(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    // Result checker and receive-side back-pressure.
    always @(posedge i_clk) begin : result_check
        psjb_pkg::t_result got;
        psjb_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[RES_W-1:0];
            n_results++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", got.sample_out, '0);
            end else begin
                want = expected_results.pop_front();
                if (got.sample_out !== want.sample_out)
                    report_mismatch("sample_out", got.sample_out, want.sample_out);
                if (got.accepted !== want.accepted)
                    report_mismatch("accepted", 16'(got.accepted), 16'(want.accepted));
                if (got.drop_reason !== want.drop_reason)
                    report_mismatch("drop_reason", 16'(got.drop_reason), 16'(want.drop_reason));
                if (got.start_dac !== want.start_dac)
                    report_mismatch("start_dac", 16'(got.start_dac), 16'(want.start_dac));
                if (got.status_due !== want.status_due)
                    report_mismatch("status_due", 16'(got.status_due), 16'(want.status_due));
                if (got.status_fill !== want.status_fill)
                    report_mismatch("status_fill", 16'(got.status_fill), 16'(want.status_fill));
                if (got.status_index !== want.status_index)
                    report_mismatch("status_index", got.status_index, want.status_index);
                if (got.error_flags !== want.error_flags)
                    report_mismatch("error_flags", 16'(got.error_flags), 16'(want.error_flags));
                if (got.expected_index !== want.expected_index)
                    report_mismatch("expected_index", got.expected_index, want.expected_index);
                if (o_m_tdata[psjb_pkg::OUT_W-1:RES_W] !== '0)
                    report_mismatch("pad bits", 16'(o_m_tdata[psjb_pkg::OUT_W-1:RES_W]), '0);
            end
        end
        i_m_tready <= no_idle || ($urandom_range(0, 99) >= 10);
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles, %0d results owed",
                     stall_cycles, expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Main stimulus sequence.
    initial begin : stimulus
        // Directed table: reset state, extremes, every request code and the corner cases.
        dir_tab.push_back('{psjb_pkg::REQ_PULL, 16'h0000, 16'h0000, 1'b1,
                            directed_result(psjb_pkg::IDLE_LEVEL_RST, 1'b0,
                                            psjb_pkg::DROP_NONE, psjb_pkg::FLAG_UNDERRUN)});
        dir_tab.push_back('{psjb_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 1'b1,
                            directed_result('0, 1'b0, psjb_pkg::DROP_NONE,
                                            psjb_pkg::FLAG_UNDERRUN)});
        dir_tab.push_back('{psjb_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1,
                            directed_result('0, 1'b0, psjb_pkg::DROP_NONE, '0)});
        dir_tab.push_back('{psjb_pkg::REQ_HEADER, 16'hFFFF, 16'h0000, 1'b1,
                            directed_result('0, 1'b0, psjb_pkg::DROP_INDEX, '0)});
        dir_tab.push_back('{psjb_pkg::REQ_HEADER, 16'h0001, 16'hFFFF, 1'b1,
                            directed_result('0, 1'b0, psjb_pkg::DROP_INDEX, '0)});
        dir_tab.push_back('{psjb_pkg::REQ_SAMPLE, 16'h0000, 16'hFFFF, 1'b1,
                            directed_result('0, 1'b0, psjb_pkg::DROP_NONE, '0)});
        dir_tab.push_back('{psjb_pkg::REQ_HEADER, 16'h0000, 16'h0000, 1'b1,
                            directed_result('0, 1'b1, psjb_pkg::DROP_NONE, '0)});
        dir_tab.push_back('{psjb_pkg::REQ_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, '0});
        dir_tab.push_back('{psjb_pkg::REQ_SAMPLE, 16'hFFFF, 16'h0000, 1'b0, '0});
        // Staged samples are not visible to a pull yet.
        dir_tab.push_back('{psjb_pkg::REQ_PULL, 16'h0000, 16'h0000, 1'b1,
                            directed_result(psjb_pkg::IDLE_LEVEL_RST, 1'b0,
                                            psjb_pkg::DROP_NONE, psjb_pkg::FLAG_UNDERRUN)});
        // A header while a packet is open restarts it.
        dir_tab.push_back('{psjb_pkg::REQ_HEADER, 16'h0000, 16'h0000, 1'b1,
                            directed_result('0, 1'b1, psjb_pkg::DROP_NONE,
                                            psjb_pkg::FLAG_UNDERRUN)});
        dir_tab.push_back('{psjb_pkg::REQ_SAMPLE, 16'hAAAA, 16'h5555, 1'b0, '0});
        dir_tab.push_back('{psjb_pkg::REQ_ARM, 16'h0000, 16'h0000, 1'b1,
                            directed_result('0, 1'b0, psjb_pkg::DROP_NONE,
                                            psjb_pkg::FLAG_UNDERRUN)});
        dir_tab.push_back('{psjb_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 1'b1,
                            directed_result('0, 1'b0, psjb_pkg::DROP_NONE,
                                            psjb_pkg::FLAG_UNDERRUN)});
        dir_tab.push_back('{REQ_UNUSED6, 16'hFFFF, 16'hFFFF, 1'b1,
                            directed_result('0, 1'b0, psjb_pkg::DROP_NONE, '0)});
        dir_tab.push_back('{REQ_UNUSED7, 16'hFFFF, 16'hFFFF, 1'b1,
                            directed_result('0, 1'b0, psjb_pkg::DROP_NONE, '0)});
        dir_tab.push_back('{psjb_pkg::REQ_SRST, 16'h0000, 16'h0000, 1'b1,
                            directed_result('0, 1'b0, psjb_pkg::DROP_NONE, '0)});
        dir_tab.push_back('{psjb_pkg::REQ_SAMPLE, 16'h1234, 16'h1234, 1'b1,
                            directed_result('0, 1'b0, psjb_pkg::DROP_NONE, '0)});
        dir_tab.push_back('{psjb_pkg::REQ_HEADER, 16'h0000, 16'h0000, 1'b1,
                            directed_result('0, 1'b1, psjb_pkg::DROP_NONE, '0)});
        dir_tab.push_back('{psjb_pkg::REQ_SAMPLE, 16'h5555, 16'hAAAA, 1'b0, '0});
        dir_tab.push_back('{psjb_pkg::REQ_SRST, 16'hFFFF, 16'hFFFF, 1'b0, '0});

        // Predictor starts from the reset state.
        clear_buffer_state();
        rx_on       = 1'b1;
        idle_val    = psjb_pkg::IDLE_LEVEL_RST;
        prefill_val = psjb_pkg::PREFILL_RST;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            send_checked(dir_tab[k].req, dir_tab[k].pidx, dir_tab[k].sval,
                         dir_tab[k].fixed, dir_tab[k].want);
        end

        // Threshold at zero: an armed start fires with the next committed packet.
        wait_results_done();
        cfg_write(psjb_pkg::CFG_IDLE_LEVEL, 16'hFFFF);
        cfg_write(psjb_pkg::CFG_PREFILL, 16'h0000);
        send(psjb_pkg::REQ_ARM, 16'($urandom), 16'($urandom));
        send_packet(20);
        // Drain the committed packet and run into underrun.
        while (held_count() != 0) send(psjb_pkg::REQ_PULL, 16'($urandom), 16'($urandom));
        pull_burst(3);

        // Receive disabled in the middle of an open packet; it resumes afterwards.
        send(psjb_pkg::REQ_HEADER, exp_index, 16'($urandom));
        repeat (100) send(psjb_pkg::REQ_SAMPLE, 16'($urandom), 16'($urandom));
        wait_results_done();
        cfg_write(psjb_pkg::CFG_RX_ENABLE, 16'h0000);
        repeat (60) send(3'($urandom_range(0, 4)), 16'($urandom), 16'($urandom));
        wait_results_done();
        cfg_write(psjb_pkg::CFG_RX_ENABLE, 16'h0001);
        while (pkt_open) send(psjb_pkg::REQ_SAMPLE, 16'($urandom), 16'($urandom));

        // Arm while already above threshold; the start waits for the next packet.
        wait_results_done();
        cfg_write(psjb_pkg::CFG_PREFILL, 16'd100);
        send(psjb_pkg::REQ_ARM, 16'($urandom), 16'($urandom));
        pull_burst(10);
        no_idle = 1'b1;
        send_packet(0);
        no_idle = 1'b0;
        // A header with an index one past the expected one, right after a commit.
        send(psjb_pkg::REQ_HEADER, exp_index + 1'b1, 16'($urandom));

        // Random register settings.
        wait_results_done();
        cfg_write(psjb_pkg::CFG_IDLE_LEVEL, 16'($urandom));
        cfg_write(psjb_pkg::CFG_PREFILL, 16'($urandom_range(0, 1023)));
        cfg_write(psjb_pkg::CFG_RX_ENABLE, 16'h0001);
        send(psjb_pkg::REQ_ARM, 16'($urandom), 16'($urandom));
        random_mix(350, 35);

        // Let every owed result arrive, then report.
        wait_results_done();
        repeat (16) @(posedge i_clk);
        $display("Run covered %0d input items and %0d result items: %0d packets opened,",
                 n_items, n_results, n_accepted);
        $display("%0d headers dropped, %0d DAC starts, %0d status reports, %0d mismatches.",
                 n_drops, n_starts, n_status, n_errors);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/psjb_pkg.sv
sv/psjb_ram.sv
sv/packet_sample_jitter_buffer.sv
sim/tb.sv
